@@ rtl/sdl_pkg.sv @@
// ----------------------------------------------------------------------------
// sdl_pkg
// Shared types and codes for the sorted dictionary lookup block.
// ----------------------------------------------------------------------------
package sdl_pkg;

   localparam int WORD_W = 64;

   typedef logic [WORD_W-1:0] word_type;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [1:0] RSP_STORED    = 2'd0;
   localparam logic [1:0] RSP_FOUND     = 2'd1;
   localparam logic [1:0] RSP_NOT_FOUND = 2'd2;
   localparam logic [1:0] RSP_FULL      = 2'd3;

   // What one cell shows its right-hand neighbor.
   typedef struct packed {
      logic     valid;
      logic     gt;       // empty, or foreign word above the key
      logic     eq;       // holds the key
      word_type foreign;
      word_type english;
   } cell_link_type;

   // Leaf and node of the match reduction tree.
   typedef struct packed {
      logic     found;
      word_type word;
   } hit_type;

endpackage

@@ rtl/sdl_cell.sv @@
// ----------------------------------------------------------------------------
// sdl_cell
// One table slot. Compares its word against the broadcast key and, on a
// load, either keeps its pair, takes its left neighbor's or takes the new one.
// ----------------------------------------------------------------------------
module sdl_cell
   import sdl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  word_type      key,
   input  word_type      english_word,
   input  logic          load_en,
   input  cell_link_type prev_link,
   output cell_link_type link,
   output hit_type       hit
);

   logic     valid_ff, valid_in;
   word_type foreign_ff, foreign_in;
   word_type english_ff, english_in;
   logic     gt, eq, shift;

   assign gt    = !valid_ff || (foreign_ff > key);
   assign eq    = valid_ff && (foreign_ff == key);
   assign shift = load_en && gt;

   always_comb begin
      valid_in   = valid_ff;
      foreign_in = foreign_ff;
      english_in = english_ff;
      if (shift) begin
         if (prev_link.gt) begin
            valid_in   = prev_link.valid;
            foreign_in = prev_link.foreign;
            english_in = prev_link.english;
         end else begin
            valid_in   = 1'b1;
            foreign_in = key;
            english_in = english_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      foreign_ff <= foreign_in;
      english_ff <= english_in;
   end

   assign link.valid   = valid_ff;
   assign link.gt      = gt;
   assign link.eq      = eq;
   assign link.foreign = foreign_ff;
   assign link.english = english_ff;

   // first of a run of equal words is the earliest inserted
   assign hit.found = eq && !prev_link.eq;
   assign hit.word  = hit.found ? english_ff : '0;

endmodule

@@ rtl/sdl_or_tree.sv @@
// ----------------------------------------------------------------------------
// sdl_or_tree
// Registered 4-ary OR tree over the cell hits; each level of nodes is
// registered, and the root is the top node.
// ----------------------------------------------------------------------------
module sdl_or_tree
   import sdl_pkg::*;
#(
   parameter int LEAVES = 1024,
   parameter int LEVELS = 5
)
(
   input  logic    clock,
   input  hit_type leaf [LEAVES],
   output hit_type root
);

   localparam int PADDED = 1 << (2 * LEVELS);
   localparam int INNER  = (PADDED - 1) / 3;

   hit_type node_ff [INNER];

   for (genvar n = 0; n < INNER; n++) begin : g_node
      hit_type kid [4];
      for (genvar k = 0; k < 4; k++) begin : g_kid
         localparam int C = 4 * n + 1 + k;
         if (C >= INNER) begin : g_leaf
            if (C - INNER < LEAVES) begin : g_used
               assign kid[k] = leaf[C - INNER];
            end else begin : g_pad
               assign kid[k] = '0;
            end
         end else begin : g_inner
            assign kid[k] = node_ff[C];
         end
      end
      always_ff @(posedge clock) begin
         node_ff[n] <= kid[0] | kid[1] | kid[2] | kid[3];
      end
   end

   assign root = node_ff[0];

endmodule

@@ rtl/sorted_dictionary_lookup.sv @@
// ----------------------------------------------------------------------------
// sorted_dictionary_lookup
// Word-pair dictionary kept sorted by foreign word in a row of cells.
// ----------------------------------------------------------------------------
//   channel | direction | beat
//   req_    | in        | kind, foreign_word, english_word
//   rsp_    | out       | status, translation
//
// On a load every cell compares the key at once and the cells above the
// insert point shift right by one.
// A query waits in the search state while its key runs through the
// registered match OR tree, LEVELS = ceil(log4(TABLE_DEPTH)) levels deep.
// Its answer enters the output register once that register is free, and the
// next beat can be taken while it is shown. Reset clears the cell valid bits.
// A stalled result holds in the output register; a new beat is taken as
// soon as that register is free or being emptied and no query is searching.
// ----------------------------------------------------------------------------
module sorted_dictionary_lookup
   import sdl_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   parameter int WORD_BYTES  = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [63:0] req_foreign_word,
   input  logic [63:0] req_english_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_translation
);

   localparam int LEVELS = ($clog2(TABLE_DEPTH) + 1) / 2;
   localparam int CW     = $clog2(LEVELS + 1);
   localparam logic [CW-1:0] LAST_CNT = CW'(LEVELS);
   localparam word_type WORD_MASK = ~64'd0 << (64 - 8 * WORD_BYTES);

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_SEARCH = 1'b1;

   logic          state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   word_type      key_ff, key_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   word_type      rsp_word_ff, rsp_word_in;

   word_type      in_foreign, in_english, key;
   logic          out_free, accept, full, load_en;
   cell_link_type links [TABLE_DEPTH];
   hit_type       hits  [TABLE_DEPTH];
   hit_type       root;

   assign in_foreign = req_foreign_word & WORD_MASK;
   assign in_english = req_english_word & WORD_MASK;
   assign key        = (state_ff == S_IDLE) ? in_foreign : key_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign full      = links[TABLE_DEPTH-1].valid;
   assign load_en   = accept && (req_kind == KIND_LOAD) && !full;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      cell_link_type prev;
      if (i == 0) begin : g_head
         assign prev = '0;
      end else begin : g_body
         assign prev = links[i-1];
      end
      sdl_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .key          (key),
         .english_word (in_english),
         .load_en      (load_en),
         .prev_link    (prev),
         .link         (links[i]),
         .hit          (hits[i])
      );
   end

   sdl_or_tree #(
      .LEAVES (TABLE_DEPTH),
      .LEVELS (LEVELS)
   ) u_tree (
      .clock (clock),
      .leaf  (hits),
      .root  (root)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_LOAD) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = full ? RSP_FULL : RSP_STORED;
                  rsp_word_in   = '0;
               end else begin
                  state_in = S_SEARCH;
                  cnt_in   = '0;
                  key_in   = in_foreign;
               end
            end
         end
         S_SEARCH: begin
            if (cnt_ff != LAST_CNT) begin
               cnt_in = cnt_ff + CW'(1);
            end else if (out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = root.found ? RSP_FOUND : RSP_NOT_FOUND;
               rsp_word_in   = root.word;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_translation = rsp_word_ff;

   a_word_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != RSP_FOUND) |-> rsp_word_ff == '0)
      else $error("translation nonzero without a hit");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      links[1].valid |-> links[0].valid && (links[0].foreign <= links[1].foreign))
      else $error("cell row out of order");

   a_load_answers: assert property (@(posedge clock) disable iff (reset)
      accept && (req_kind == KIND_LOAD) |=>
         rsp_valid_ff && ((rsp_status_ff == RSP_STORED) || (rsp_status_ff == RSP_FULL)))
      else $error("load beat without answer");

   a_search_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |-> req_stall)
      else $error("beat taken during search");

endmodule
